### rtl/core/qacs_pkg.sv
// Shared types and constants of the quote-aware comment stripper.
package qacs_pkg;

  localparam int CharW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = CharW;

  localparam logic [CharW-1:0] OpenCharRst = 16'd35;    // '#'
  localparam logic [CharW-1:0] CloseCharRst = 16'd10;   // newline
  localparam logic [CharW-1:0] QuoteCharRst = 16'd34;   // '"'
  localparam logic [CharW-1:0] ShieldCharRst = 16'd92;  // backslash
  localparam logic QuoteModeRst = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN   = 3'd0,
    REG_CLOSE  = 3'd1,
    REG_QUOTE  = 3'd2,
    REG_SHIELD = 3'd3,
    REG_QMODE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CharW-1:0] open_char;
    logic [CharW-1:0] close_char;
    logic [CharW-1:0] quote_char;
    logic [CharW-1:0] shield_char;
    logic             quote_mode;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic             keep;
    logic             last;
    logic [CharW-1:0] ch;
  } verdict_t;

endpackage

### rtl/core/qacs_if.sv
// Stream channel interfaces: character input and filtered result output.
interface qacs_in_if;
  logic                         valid;
  logic                         ready;
  logic [qacs_pkg::CharW-1:0]   in_char;
  logic                         in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink (input valid, in_char, in_last, output ready);
endinterface

interface qacs_out_if;
  logic                         valid;
  logic                         ready;
  logic [qacs_pkg::CharW-1:0]   out_char;
  logic                         out_valid;
  logic                         out_last;

  modport source (output valid, out_char, out_valid, out_last, input ready);
  modport sink (input valid, out_char, out_valid, out_last, output ready);
endinterface

### rtl/core/quote_aware_comment_stripper_unit.sv
// Top level of the quote-aware comment stripper.
// Takes one 16-bit character per cycle and passes on the kept ones, dropping
// every run from the open character through the close character (both
// included); with quote mode set, quoted runs are protected. Throughput is one
// character per clock: the decision is one compare stage between the input
// register and the result register, and both registers advance together
// whenever the result register is empty or being taken. The result register
// loads from the input register. A dropped character gives no result unless
// it is the last of the stream, which always gives one result with out_last
// set (out_valid low, out_char zero when that character was dropped); the
// tracking state then returns to idle. Registers: 0 open, 1 close, 2 quote,
// 3 shield, 4 quote mode; write them only while the block is idle.
module quote_aware_comment_stripper_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qacs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [qacs_pkg::CfgDataW-1:0] cfg_data,
  qacs_in_if.sink                       in_ch,
  qacs_out_if.source                    out_ch
);
  import qacs_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_last;
  logic             s1_fire;
  logic             out_free;
  verdict_t         verdict;
  logic             o_valid;
  logic [CharW-1:0] o_char;
  logic             o_flag;
  logic             o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_char   <= OpenCharRst;
      cfg.close_char  <= CloseCharRst;
      cfg.quote_char  <= QuoteCharRst;
      cfg.shield_char <= ShieldCharRst;
      cfg.quote_mode  <= QuoteModeRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OPEN:   cfg.open_char   <= cfg_data;
        REG_CLOSE:  cfg.close_char  <= cfg_data;
        REG_QUOTE:  cfg.quote_char  <= cfg_data;
        REG_SHIELD: cfg.shield_char <= cfg_data;
        REG_QMODE:  cfg.quote_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free     = !o_valid || out_ch.ready;
  assign s1_fire      = s1_valid && out_free;
  assign in_ch.ready  = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char <= in_ch.in_char;
      s1_last <= in_ch.in_last;
    end
  end

  qacs_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ch      (s1_char),
    .last    (s1_last),
    .advance (s1_fire),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire && verdict.emit) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && verdict.emit) begin
      o_char <= verdict.ch;
      o_flag <= verdict.keep;
      o_last <= verdict.last;
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.out_char  = o_char;
  assign out_ch.out_valid = o_flag;
  assign out_ch.out_last  = o_last;

  // an end-only marker is only ever produced for the last character
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_flag |-> o_last)
    else $error("end-only marker without last flag");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_flag |-> o_char == '0)
    else $error("dropped character leaked into result");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_char) && $stable(s1_last))
    else $error("input stage lost or changed a waiting transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    o_valid && !out_ch.ready |=> o_valid && $stable(o_char) && $stable(o_last))
    else $error("result register overwritten while stalled");

endmodule

### rtl/core/qacs_filter.sv
// Section/quote tracking state and keep/drop decision for one character.
module qacs_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  qacs_pkg::cfg_t             cfg,
  input  logic [qacs_pkg::CharW-1:0] ch,
  input  logic                       last,
  input  logic                       advance,
  output qacs_pkg::verdict_t         verdict
);
  import qacs_pkg::*;

  logic             in_section, in_section_next;
  logic             in_quote, in_quote_next;
  logic [CharW-1:0] prev_kept, prev_kept_next;
  logic             keep;

  always_comb begin
    keep            = 1'b1;
    in_section_next = in_section;
    in_quote_next   = 1'b0;
    if (cfg.quote_mode && in_quote) begin
      // a shielded quote stays inside the run
      in_quote_next = !(ch == cfg.quote_char && prev_kept != cfg.shield_char);
    end else if (in_section) begin
      keep            = 1'b0;
      in_section_next = (ch != cfg.close_char);
    end else if (cfg.quote_mode && ch == cfg.quote_char) begin
      in_quote_next = 1'b1;
    end else if (ch == cfg.open_char) begin
      keep            = 1'b0;
      in_section_next = 1'b1;
    end
    prev_kept_next = keep ? ch : prev_kept;
    if (last) begin
      in_section_next = 1'b0;
      in_quote_next   = 1'b0;
      prev_kept_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_section <= 1'b0;
      in_quote   <= 1'b0;
      prev_kept  <= '0;
    end else if (advance) begin
      in_section <= in_section_next;
      in_quote   <= in_quote_next;
      prev_kept  <= prev_kept_next;
    end
  end

  assign verdict.emit = keep || last;
  assign verdict.keep = keep;
  assign verdict.last = last;
  assign verdict.ch   = keep ? ch : '0;

endmodule
